// ===== design/tgr_pkg.sv =====
// ----------------------------------------------------------------------------
// tgr_pkg
// Shared types, codes and reset values of the touch gesture recognizer.
// ----------------------------------------------------------------------------
package tgr_pkg;

   localparam int TGR_QUEUE_DEPTH = 2;

   localparam int COORD_W = 12;
   localparam int TIME_W  = 48;
   localparam int FUNC_W  = 3;
   localparam int KIND_W  = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Request kinds as they arrive on the stream.
   localparam logic [FUNC_W-1:0] FUNC_DOWN   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_MOVE   = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_UP     = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_CANCEL = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_TICK   = 3'd4;

   // Gesture codes on the response stream.
   localparam logic [KIND_W-1:0] GESTURE_TAP         = 3'd0;
   localparam logic [KIND_W-1:0] GESTURE_LONG_PRESS  = 3'd1;
   localparam logic [KIND_W-1:0] GESTURE_SWIPE_LEFT  = 3'd2;
   localparam logic [KIND_W-1:0] GESTURE_SWIPE_RIGHT = 3'd3;
   localparam logic [KIND_W-1:0] GESTURE_SWIPE_UP    = 3'd4;
   localparam logic [KIND_W-1:0] GESTURE_SWIPE_DOWN  = 3'd5;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_TAP_DISTANCE_LIMIT     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SWIPE_DISTANCE_MIN     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_RATIO_NUMERATOR   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_RATIO_DENOMINATOR = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TAP_TIME_LIMIT         = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS_TIME        = 3'd5;

   localparam logic [11:0] RST_TAP_DISTANCE_LIMIT     = 12'd24;
   localparam logic [11:0] RST_SWIPE_DISTANCE_MIN     = 12'd60;
   localparam logic [7:0]  RST_AXIS_RATIO_NUMERATOR   = 8'd1;
   localparam logic [7:0]  RST_AXIS_RATIO_DENOMINATOR = 8'd2;
   localparam logic [31:0] RST_TAP_TIME_LIMIT         = 32'd300000;
   localparam logic [31:0] RST_LONG_PRESS_TIME        = 32'd600000;

   typedef enum logic [2:0] {
      CMD_DOWN,
      CMD_MOVE,
      CMD_UP,
      CMD_CANCEL,
      CMD_TICK
   } cmd_type;

   typedef struct packed {
      cmd_type             cmd;
      logic [COORD_W-1:0]  pos_x;
      logic [COORD_W-1:0]  pos_y;
      logic [TIME_W-1:0]   time_us;
   } item_type;

   typedef struct packed {
      logic [11:0] tap_distance_limit;
      logic [11:0] swipe_distance_min;
      logic [7:0]  axis_ratio_numerator;
      logic [7:0]  axis_ratio_denominator;
      logic [31:0] tap_time_limit;
      logic [31:0] long_press_time;
   } cfg_type;

endpackage

// ===== design/tgr_front.sv =====
// ----------------------------------------------------------------------------
// tgr_front
// Input stage: accepts requests, decodes the kind and drops unknown kinds.
// ----------------------------------------------------------------------------
module tgr_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [tgr_pkg::FUNC_W-1:0]   in_func,
   input  logic [tgr_pkg::COORD_W-1:0]  in_pos_x,
   input  logic [tgr_pkg::COORD_W-1:0]  in_pos_y,
   input  logic [tgr_pkg::TIME_W-1:0]   in_time_us,
   output logic                         push_valid,
   input  logic                         push_ready,
   output tgr_pkg::item_type            push_item
);
   import tgr_pkg::*;

   logic     front_valid_ff, front_valid_in;
   item_type front_item_ff, front_item_in;
   logic     known;
   cmd_type  cmd;
   logic     accept;

   always_comb begin
      known = 1'b1;
      cmd   = CMD_DOWN;
      case (in_func)
         FUNC_DOWN:   cmd = CMD_DOWN;
         FUNC_MOVE:   cmd = CMD_MOVE;
         FUNC_UP:     cmd = CMD_UP;
         FUNC_CANCEL: cmd = CMD_CANCEL;
         FUNC_TICK:   cmd = CMD_TICK;
         default:     known = 1'b0;
      endcase
   end

   assign in_ready = !front_valid_ff || push_ready;
   assign accept   = in_valid && in_ready;

   always_comb begin
      front_valid_in = front_valid_ff;
      front_item_in  = front_item_ff;
      if (accept) begin
         // Unknown kinds change nothing downstream, so they are consumed here.
         front_valid_in        = known;
         front_item_in.cmd     = cmd;
         front_item_in.pos_x   = in_pos_x;
         front_item_in.pos_y   = in_pos_y;
         front_item_in.time_us = in_time_us;
      end else if (push_ready) begin
         front_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
      front_item_ff <= front_item_in;
   end

   assign push_valid = front_valid_ff;
   assign push_item  = front_item_ff;

endmodule

// ===== design/tgr_queue.sv =====
// ----------------------------------------------------------------------------
// tgr_queue
// Small FIFO of decoded requests between the front and back stages.
// ----------------------------------------------------------------------------
module tgr_queue #(
   parameter int DEPTH = tgr_pkg::TGR_QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  tgr_pkg::item_type  push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output tgr_pkg::item_type  pop_item
);
   import tgr_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   item_type         slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== design/tgr_back.sv =====
// ----------------------------------------------------------------------------
// tgr_back
// Press state and gesture classification, with a registered response.
// ----------------------------------------------------------------------------
module tgr_back (
   input  logic                         clock,
   input  logic                         reset,
   input  tgr_pkg::cfg_type             cfg,
   input  logic                         head_valid,
   output logic                         head_ready,
   input  tgr_pkg::item_type            head_item,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [tgr_pkg::KIND_W-1:0]   out_kind,
   output logic [tgr_pkg::COORD_W-1:0]  out_origin_x,
   output logic [tgr_pkg::COORD_W-1:0]  out_origin_y,
   output logic [tgr_pkg::TIME_W-1:0]   out_time_us
);
   import tgr_pkg::*;

   localparam int PROD_W = COORD_W + 8;

   logic               active_ff, active_in;
   logic               long_done_ff, long_done_in;
   logic               moved_ff, moved_in;
   logic [COORD_W-1:0] down_x_ff, down_x_in;
   logic [COORD_W-1:0] down_y_ff, down_y_in;
   logic [TIME_W-1:0]  down_time_ff, down_time_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]  rsp_kind_ff, rsp_kind_in;
   logic [COORD_W-1:0] rsp_x_ff, rsp_x_in;
   logic [COORD_W-1:0] rsp_y_ff, rsp_y_in;
   logic [TIME_W-1:0]  rsp_time_ff, rsp_time_in;

   logic               advance;
   logic [COORD_W-1:0] adx, ady;
   logic [PROD_W-1:0]  ady_den, adx_num, adx_den, ady_num;
   logic [TIME_W-1:0]  held;
   logic               h_swipe, v_swipe, tap_ok, far, long_ok;
   logic               emit;
   logic [KIND_W-1:0]  kind;

   assign head_ready = !rsp_valid_ff || out_ready;
   assign advance    = head_valid && head_ready;

   assign adx = (head_item.pos_x >= down_x_ff) ? head_item.pos_x - down_x_ff
                                               : down_x_ff - head_item.pos_x;
   assign ady = (head_item.pos_y >= down_y_ff) ? head_item.pos_y - down_y_ff
                                               : down_y_ff - head_item.pos_y;

   assign ady_den = {8'b0, ady} * {12'b0, cfg.axis_ratio_denominator};
   assign adx_num = {8'b0, adx} * {12'b0, cfg.axis_ratio_numerator};
   assign adx_den = {8'b0, adx} * {12'b0, cfg.axis_ratio_denominator};
   assign ady_num = {8'b0, ady} * {12'b0, cfg.axis_ratio_numerator};

   // Hold time wraps modulo 2^48 and is compared as a signed value.
   assign held = head_item.time_us - down_time_ff;

   assign far     = (adx > cfg.tap_distance_limit) || (ady > cfg.tap_distance_limit);
   assign h_swipe = (adx >= cfg.swipe_distance_min) && (ady_den <= adx_num);
   assign v_swipe = (ady >= cfg.swipe_distance_min) && (adx_den <= ady_num);
   assign tap_ok  = !moved_ff && !far &&
                    ($signed(held) <= $signed({16'b0, cfg.tap_time_limit}));
   assign long_ok = $signed(held) >= $signed({16'b0, cfg.long_press_time});

   always_comb begin
      active_in    = active_ff;
      long_done_in = long_done_ff;
      moved_in     = moved_ff;
      down_x_in    = down_x_ff;
      down_y_in    = down_y_ff;
      down_time_in = down_time_ff;
      emit         = 1'b0;
      kind         = GESTURE_TAP;
      case (head_item.cmd)
         CMD_DOWN: begin
            active_in    = 1'b1;
            long_done_in = 1'b0;
            moved_in     = 1'b0;
            down_x_in    = head_item.pos_x;
            down_y_in    = head_item.pos_y;
            down_time_in = head_item.time_us;
         end
         CMD_MOVE: begin
            if (active_ff && far) begin
               moved_in = 1'b1;
            end
         end
         CMD_UP: begin
            if (active_ff) begin
               active_in = 1'b0;
               if (!long_done_ff) begin
                  if (h_swipe) begin
                     emit = 1'b1;
                     kind = (head_item.pos_x > down_x_ff) ? GESTURE_SWIPE_RIGHT
                                                          : GESTURE_SWIPE_LEFT;
                  end else if (v_swipe) begin
                     emit = 1'b1;
                     kind = (head_item.pos_y > down_y_ff) ? GESTURE_SWIPE_DOWN
                                                          : GESTURE_SWIPE_UP;
                  end else if (tap_ok) begin
                     emit = 1'b1;
                     kind = GESTURE_TAP;
                  end
               end
            end
         end
         CMD_CANCEL: begin
            active_in = 1'b0;
         end
         CMD_TICK: begin
            if (active_ff && !long_done_ff && !moved_ff && long_ok) begin
               long_done_in = 1'b1;
               emit         = 1'b1;
               kind         = GESTURE_LONG_PRESS;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_time_in  = rsp_time_ff;
      if (advance) begin
         rsp_valid_in = emit;
         rsp_kind_in  = kind;
         rsp_x_in     = down_x_ff;
         rsp_y_in     = down_y_ff;
         rsp_time_in  = head_item.time_us;
      end else if (out_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         long_done_ff <= 1'b0;
         moved_ff     <= 1'b0;
         down_x_ff    <= '0;
         down_y_ff    <= '0;
         down_time_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            active_ff    <= active_in;
            long_done_ff <= long_done_in;
            moved_ff     <= moved_in;
            down_x_ff    <= down_x_in;
            down_y_ff    <= down_y_in;
            down_time_ff <= down_time_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_kind_ff <= rsp_kind_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_time_ff <= rsp_time_in;
   end

   assign out_valid    = rsp_valid_ff;
   assign out_kind     = rsp_kind_ff;
   assign out_origin_x = rsp_x_ff;
   assign out_origin_y = rsp_y_ff;
   assign out_time_us  = rsp_time_ff;

endmodule

// ===== design/touch_gesture_recognizer.sv =====
// ----------------------------------------------------------------------------
// touch_gesture_recognizer
// Turns pointer and tick requests into tap, long press and swipe gestures.
//
//   Channel  Direction  Handshake              Contents
//   req_     in         req_tvalid/req_tready  tuser: func; tdata: x, y, time
//   rsp_     out        rsp_tvalid/rsp_tready  tuser: gesture; tdata: x, y, time
//   csr_     in         csr_we                 index and 32-bit write data
//
// One request per cycle is accepted while req_tready is high; a request passes
// the front register, the queue and the response register, in that order.
// The back stage retires one queued request per cycle unless the response
// stalls, which sets the rate. A stalled response holds the back stage; the
// queue and front register take requests until they fill. Reset is synchronous.
// ----------------------------------------------------------------------------
module touch_gesture_recognizer #(
   parameter int QUEUE_DEPTH = tgr_pkg::TGR_QUEUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [tgr_pkg::FUNC_W-1:0]       req_tuser,  // [2:0] func
   input  logic [71:0]                      req_tdata,  // pos_x, pos_y, time_us
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [tgr_pkg::KIND_W-1:0]       rsp_tuser,  // [2:0] gesture_kind
   output logic [71:0]                      rsp_tdata,  // origin_x, origin_y, time
   input  logic                             csr_we,
   input  logic [tgr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tgr_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tgr_pkg::*;

   cfg_type            cfg_ff, cfg_in;
   logic               push_valid, push_ready;
   item_type           push_item;
   logic               head_valid, head_ready;
   item_type           head_item;
   logic [COORD_W-1:0] out_x, out_y;
   logic [TIME_W-1:0]  out_time;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TAP_DISTANCE_LIMIT:     cfg_in.tap_distance_limit     = csr_wdata[11:0];
            CSR_SWIPE_DISTANCE_MIN:     cfg_in.swipe_distance_min     = csr_wdata[11:0];
            CSR_AXIS_RATIO_NUMERATOR:   cfg_in.axis_ratio_numerator   = csr_wdata[7:0];
            CSR_AXIS_RATIO_DENOMINATOR: cfg_in.axis_ratio_denominator = csr_wdata[7:0];
            CSR_TAP_TIME_LIMIT:         cfg_in.tap_time_limit         = csr_wdata;
            CSR_LONG_PRESS_TIME:        cfg_in.long_press_time        = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tap_distance_limit     <= RST_TAP_DISTANCE_LIMIT;
         cfg_ff.swipe_distance_min     <= RST_SWIPE_DISTANCE_MIN;
         cfg_ff.axis_ratio_numerator   <= RST_AXIS_RATIO_NUMERATOR;
         cfg_ff.axis_ratio_denominator <= RST_AXIS_RATIO_DENOMINATOR;
         cfg_ff.tap_time_limit         <= RST_TAP_TIME_LIMIT;
         cfg_ff.long_press_time        <= RST_LONG_PRESS_TIME;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tgr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_func    (req_tuser),
      .in_pos_x   (req_tdata[11:0]),
      .in_pos_y   (req_tdata[23:12]),
      .in_time_us (req_tdata[71:24]),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   tgr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (head_valid),
      .pop_ready  (head_ready),
      .pop_item   (head_item)
   );

   tgr_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .head_valid   (head_valid),
      .head_ready   (head_ready),
      .head_item    (head_item),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_kind     (rsp_tuser),
      .out_origin_x (out_x),
      .out_origin_y (out_y),
      .out_time_us  (out_time)
   );

   assign rsp_tdata = {out_time, out_y, out_x};

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Touch gesture recognizer testbench
// Sends pointer and tick requests through the request stream, predicts each
// gesture with an independent model of the press state and compares every
// response field by field. A short directed table comes first, then random
// press sequences under several register settings, with bursty requests,
// response stalls and one long response hold-off.
// ----------------------------------------------------------------------------
module testbench;
   import tgr_pkg::*;

   localparam int HALF_PERIOD    = 10;
   localparam int RESET_CYCLES   = 12;
   localparam int DRAIN_CYCLES   = 20;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int MAX_COORD      = 4095;
   localparam int MAX_REPORTS    = 50;

   // A request kind the block does not know.
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 3'd7;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [TIME_W-1:0]  stamp;
   } gesture_type;

   typedef enum {BY_PREDICTOR, TYPED_NONE, TYPED_GESTURE} row_check_type;

   typedef struct {
      logic [FUNC_W-1:0]  func;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [TIME_W-1:0]  t;
      row_check_type      check;
      gesture_type        want;
   } request_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [FUNC_W-1:0]     req_tuser;
   logic [71:0]           req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [KIND_W-1:0]     rsp_tuser;
   logic [71:0]           rsp_tdata;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Predicted press state and register copy.
   cfg_type            cfg_now;
   bit                 press_on;
   bit                 long_fired;
   bit                 strayed;
   logic [COORD_W-1:0] anchor_x;
   logic [COORD_W-1:0] anchor_y;
   logic [TIME_W-1:0]  anchor_time;

   gesture_type  pending_gestures[$];
   request_type  directed_rows[$];
   gesture_type  expected_gesture;
   gesture_type  seen_gesture;
   logic [47:0]  clock_us;
   int           items_sent;
   int           burst_left;
   int           error_count;
   int           cycle_count;
   bit           holdoff_pending;
   int           stall_mode;
   int           stall_left;
   logic [7:0]   stall_pattern;
   logic [2:0]   stall_phase;

   touch_gesture_recognizer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic int unsigned travel(input logic [COORD_W-1:0] a,
                                          input logic [COORD_W-1:0] b);
      return (a >= b) ? int'(a) - int'(b) : int'(b) - int'(a);
   endfunction

   function automatic logic [47:0] any_time();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[47:0];
   endfunction

   // Moves a coordinate by reach in a random direction, clamped to the screen.
   function automatic logic [COORD_W-1:0] nudge(input logic [COORD_W-1:0] base,
                                                input int reach);
      int v;
      v = ($urandom_range(0, 1) == 1) ? int'(base) + reach : int'(base) - reach;
      if (v < 0) v = 0;
      if (v > MAX_COORD) v = MAX_COORD;
      return v[COORD_W-1:0];
   endfunction

   function automatic request_type plain(input logic [FUNC_W-1:0] f, input int x,
                                         input int y, input logic [47:0] t);
      request_type r;
      r.func  = f;
      r.x     = x[COORD_W-1:0];
      r.y     = y[COORD_W-1:0];
      r.t     = t;
      r.check = BY_PREDICTOR;
      r.want  = '0;
      return r;
   endfunction

   function automatic request_type expect_gesture(input request_type r,
                                                  input logic [KIND_W-1:0] kind,
                                                  input int ox, input int oy);
      request_type e;
      e = r;
      e.check      = TYPED_GESTURE;
      e.want.kind  = kind;
      e.want.x     = ox[COORD_W-1:0];
      e.want.y     = oy[COORD_W-1:0];
      e.want.stamp = r.t;
      return e;
   endfunction

   function automatic request_type expect_nothing(input request_type r);
      request_type e;
      e = r;
      e.check = TYPED_NONE;
      return e;
   endfunction

   // Advances the predicted press state by one request and tells whether a
   // gesture comes out of it.
   task automatic classify_request(input request_type r, output bit fires,
                                   output gesture_type g);
      int unsigned adx;
      int unsigned ady;
      logic [47:0] span;
      longint      held;
      fires = 1'b0;
      g     = '0;
      adx   = travel(r.x, anchor_x);
      ady   = travel(r.y, anchor_y);
      span  = r.t - anchor_time;
      held  = longint'($signed(span));
      case (r.func)
         FUNC_DOWN: begin
            press_on    = 1'b1;
            long_fired  = 1'b0;
            strayed     = 1'b0;
            anchor_x    = r.x;
            anchor_y    = r.y;
            anchor_time = r.t;
         end
         FUNC_MOVE: begin
            if (press_on && (adx > cfg_now.tap_distance_limit ||
                             ady > cfg_now.tap_distance_limit))
               strayed = 1'b1;
         end
         FUNC_UP: begin
            if (press_on) begin
               press_on = 1'b0;
               if (!long_fired) begin
                  if (adx >= cfg_now.swipe_distance_min &&
                      ady * cfg_now.axis_ratio_denominator <=
                      adx * cfg_now.axis_ratio_numerator) begin
                     fires  = 1'b1;
                     g.kind = (r.x > anchor_x) ? GESTURE_SWIPE_RIGHT : GESTURE_SWIPE_LEFT;
                  end else if (ady >= cfg_now.swipe_distance_min &&
                               adx * cfg_now.axis_ratio_denominator <=
                               ady * cfg_now.axis_ratio_numerator) begin
                     fires  = 1'b1;
                     g.kind = (r.y > anchor_y) ? GESTURE_SWIPE_DOWN : GESTURE_SWIPE_UP;
                  end else if (!strayed && adx <= cfg_now.tap_distance_limit &&
                               ady <= cfg_now.tap_distance_limit &&
                               held <= longint'(cfg_now.tap_time_limit)) begin
                     fires  = 1'b1;
                     g.kind = GESTURE_TAP;
                  end
               end
            end
         end
         FUNC_CANCEL: begin
            press_on = 1'b0;
         end
         FUNC_TICK: begin
            if (press_on && !long_fired && !strayed &&
                held >= longint'(cfg_now.long_press_time)) begin
               long_fired = 1'b1;
               fires      = 1'b1;
               g.kind     = GESTURE_LONG_PRESS;
            end
         end
         default: ;
      endcase
      g.x     = anchor_x;
      g.y     = anchor_y;
      g.stamp = r.t;
   endtask

   // Offers one request, in bursts separated by random gaps, and records the
   // gesture it should produce once the block takes it.
   task automatic send_request(input request_type r);
      bit          fires;
      gesture_type g;
      int          gap;
      if (burst_left == 0) begin
         gap        = $urandom_range(0, 6);
         burst_left = $urandom_range(1, 32);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= r.func;
      req_tdata  <= {r.t, r.y, r.x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      classify_request(r, fires, g);
      case (r.check)
         BY_PREDICTOR:  if (fires) pending_gestures.push_back(g);
         TYPED_GESTURE: pending_gestures.push_back(r.want);
         default: ;
      endcase
      if (r.func <= FUNC_TICK) items_sent++;
   endtask

   task automatic pause_until_drained();
      req_tvalid <= 1'b0;
      while (pending_gestures.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Bits above the register width are filled with noise; the block drops them.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value,
                            input int width);
      logic [31:0] junk;
      junk = $urandom();
      if (width < 32) junk = junk << width;
      else junk = '0;
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= junk | value;
      @(posedge clock);
      case (idx)
         CSR_TAP_DISTANCE_LIMIT:     cfg_now.tap_distance_limit     = value[11:0];
         CSR_SWIPE_DISTANCE_MIN:     cfg_now.swipe_distance_min     = value[11:0];
         CSR_AXIS_RATIO_NUMERATOR:   cfg_now.axis_ratio_numerator   = value[7:0];
         CSR_AXIS_RATIO_DENOMINATOR: cfg_now.axis_ratio_denominator = value[7:0];
         CSR_TAP_TIME_LIMIT:         cfg_now.tap_time_limit         = value;
         CSR_LONG_PRESS_TIME:        cfg_now.long_press_time        = value;
         default: ;
      endcase
   endtask

   task automatic load_settings(input logic [11:0] tap_dist, input logic [11:0] swipe_min,
                                input logic [7:0] ratio_num, input logic [7:0] ratio_den,
                                input logic [31:0] tap_time, input logic [31:0] hold_time);
      write_reg(CSR_TAP_DISTANCE_LIMIT, {20'd0, tap_dist}, 12);
      write_reg(CSR_SWIPE_DISTANCE_MIN, {20'd0, swipe_min}, 12);
      write_reg(CSR_AXIS_RATIO_NUMERATOR, {24'd0, ratio_num}, 8);
      write_reg(CSR_AXIS_RATIO_DENOMINATOR, {24'd0, ratio_den}, 8);
      write_reg(CSR_TAP_TIME_LIMIT, tap_time, 32);
      write_reg(CSR_LONG_PRESS_TIME, hold_time, 32);
      csr_we <= 1'b0;
   endtask

   // One press from down to its end, with travel and timing chosen near the
   // thresholds of the current settings.
   task automatic press_sequence();
      logic [COORD_W-1:0] ox;
      logic [COORD_W-1:0] oy;
      logic [COORD_W-1:0] ux;
      logic [COORD_W-1:0] uy;
      logic [47:0]        t_down;
      logic [47:0]        t_at;
      int                 near;
      int                 far;
      int                 n;
      near   = $urandom_range(0, int'(cfg_now.tap_distance_limit) + 1);
      far    = $urandom_range(int'(cfg_now.swipe_distance_min), MAX_COORD);
      ox     = COORD_W'($urandom_range(0, MAX_COORD));
      oy     = COORD_W'($urandom_range(0, MAX_COORD));
      t_down = clock_us;
      send_request(plain(FUNC_DOWN, int'(ox), int'(oy), t_down));
      n = $urandom_range(0, 2);
      repeat (n) begin
         send_request(plain(FUNC_MOVE,
                            int'(nudge(ox, ($urandom_range(0, 3) == 0) ? far : near)),
                            int'(nudge(oy, $urandom_range(0, near))),
                            t_down + $urandom_range(1, 1000)));
      end
      n = $urandom_range(0, 2);
      repeat (n) begin
         case ($urandom_range(0, 2))
            0: t_at = t_down + {16'd0, cfg_now.long_press_time} - 48'd1;
            1: t_at = t_down + {16'd0, cfg_now.long_press_time};
            default: t_at = t_down + {16'd0, cfg_now.long_press_time} +
                            $urandom_range(1, 100000);
         endcase
         send_request(plain(FUNC_TICK, $urandom_range(0, MAX_COORD),
                            $urandom_range(0, MAX_COORD), t_at));
      end
      case ($urandom_range(0, 9))
         0: send_request(plain(FUNC_CANCEL, $urandom_range(0, MAX_COORD),
                               $urandom_range(0, MAX_COORD), t_down + 48'd5));
         1: ;  // left open: the next down restarts the press
         default: begin
            case ($urandom_range(0, 3))
               0: begin ux = nudge(ox, near); uy = nudge(oy, near); end
               1: begin ux = nudge(ox, far);  uy = nudge(oy, near); end
               2: begin ux = nudge(ox, near); uy = nudge(oy, far);  end
               default: begin
                  ux = COORD_W'($urandom_range(0, MAX_COORD));
                  uy = COORD_W'($urandom_range(0, MAX_COORD));
               end
            endcase
            case ($urandom_range(0, 3))
               0: t_at = t_down + $urandom_range(0, 1000);
               1: t_at = t_down + {16'd0, cfg_now.tap_time_limit} +
                         $urandom_range(0, 2) - 48'd1;
               2: t_at = t_down + $urandom_range(0, 3000000);
               default: t_at = any_time();
            endcase
            send_request(plain(FUNC_UP, int'(ux), int'(uy), t_at));
         end
      endcase
      clock_us = clock_us + $urandom_range(1, 5000000);
   endtask

   task automatic random_phase(input int count);
      int stop_at;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 99) < 15)
            send_request(plain(FUNC_W'($urandom_range(0, 7)), $urandom_range(0, MAX_COORD),
                               $urandom_range(0, MAX_COORD), any_time()));
         else
            press_sequence();
      end
   endtask

   task automatic report_mismatch(input string what, input logic [47:0] want,
                                  input logic [47:0] got);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("%0t: %s expected %0h got %0h", $time, what, want, got);
   endtask

   // Response side: switches between random stall patterns and holds off for a
   // long stretch when asked.
   initial begin
      rsp_tready    = 1'b0;
      stall_mode    = 0;
      stall_left    = 0;
      stall_pattern = '0;
      stall_phase   = '0;
      forever begin
         @(posedge clock);
         if (holdoff_pending) begin
            holdoff_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
         end else begin
            if (stall_left == 0) begin
               stall_mode    = $urandom_range(0, 2);
               stall_pattern = 8'($urandom_range(0, 255));
               stall_left    = $urandom_range(16, 96);
            end
            stall_left--;
            stall_phase++;
            case (stall_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= stall_pattern[stall_phase];
               default: rsp_tready <= ($urandom_range(0, 1) == 1);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_gesture.kind  = rsp_tuser;
         seen_gesture.x     = rsp_tdata[11:0];
         seen_gesture.y     = rsp_tdata[23:12];
         seen_gesture.stamp = rsp_tdata[71:24];
         if (pending_gestures.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t: gesture expected none got kind %0d at (%0d,%0d) time %0h",
                        $time, seen_gesture.kind, seen_gesture.x, seen_gesture.y,
                        seen_gesture.stamp);
         end else begin
            expected_gesture = pending_gestures.pop_front();
            if (seen_gesture.kind !== expected_gesture.kind)
               report_mismatch("gesture_kind", 48'(expected_gesture.kind),
                               48'(seen_gesture.kind));
            if (seen_gesture.x !== expected_gesture.x)
               report_mismatch("origin_x", 48'(expected_gesture.x), 48'(seen_gesture.x));
            if (seen_gesture.y !== expected_gesture.y)
               report_mismatch("origin_y", 48'(expected_gesture.y), 48'(seen_gesture.y));
            if (seen_gesture.stamp !== expected_gesture.stamp)
               report_mismatch("gesture_time_us", expected_gesture.stamp,
                               seen_gesture.stamp);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tuser       = FUNC_DOWN;
      req_tdata       = '0;
      csr_we          = 1'b0;
      csr_index       = CSR_TAP_DISTANCE_LIMIT;
      csr_wdata       = '0;
      holdoff_pending = 1'b0;
      items_sent      = 0;
      burst_left      = 0;
      error_count     = 0;
      cycle_count     = 0;
      cfg_now.tap_distance_limit     = RST_TAP_DISTANCE_LIMIT;
      cfg_now.swipe_distance_min     = RST_SWIPE_DISTANCE_MIN;
      cfg_now.axis_ratio_numerator   = RST_AXIS_RATIO_NUMERATOR;
      cfg_now.axis_ratio_denominator = RST_AXIS_RATIO_DENOMINATOR;
      cfg_now.tap_time_limit         = RST_TAP_TIME_LIMIT;
      cfg_now.long_press_time        = RST_LONG_PRESS_TIME;
      press_on    = 1'b0;
      long_fired  = 1'b0;
      strayed     = 1'b0;
      anchor_x    = '0;
      anchor_y    = '0;
      anchor_time = '0;

      // Directed requests under the reset settings.
      directed_rows.push_back(expect_nothing(plain(FUNC_UP, 5, 5, 48'd10)));
      directed_rows.push_back(expect_nothing(plain(FUNC_TICK, 0, 0, 48'd20)));
      directed_rows.push_back(expect_nothing(plain(FUNC_UNUSED, MAX_COORD, MAX_COORD,
                                                   48'hFFFF_FFFF_FFFF)));
      directed_rows.push_back(expect_nothing(plain(FUNC_DOWN, 100, 100, 48'd1000)));
      directed_rows.push_back(expect_gesture(plain(FUNC_UP, 100, 100, 48'd301000),
                                             GESTURE_TAP, 100, 100));
      directed_rows.push_back(plain(FUNC_DOWN, MAX_COORD, MAX_COORD, 48'd400000));
      directed_rows.push_back(expect_gesture(plain(FUNC_UP, 0, MAX_COORD, 48'd400100),
                                             GESTURE_SWIPE_LEFT, MAX_COORD, MAX_COORD));
      directed_rows.push_back(plain(FUNC_DOWN, 0, 0, 48'd500000));
      directed_rows.push_back(expect_gesture(plain(FUNC_UP, MAX_COORD, 0, 48'd500050),
                                             GESTURE_SWIPE_RIGHT, 0, 0));
      directed_rows.push_back(plain(FUNC_DOWN, 500, MAX_COORD, 48'd600000));
      directed_rows.push_back(expect_gesture(plain(FUNC_UP, 500, 0, 48'd600010),
                                             GESTURE_SWIPE_UP, 500, MAX_COORD));
      directed_rows.push_back(plain(FUNC_DOWN, 500, 0, 48'd700000));
      directed_rows.push_back(expect_gesture(plain(FUNC_UP, 510, MAX_COORD, 48'd700010),
                                             GESTURE_SWIPE_DOWN, 500, 0));
      // Hold still for exactly the long press time, travel right at the limit.
      directed_rows.push_back(plain(FUNC_DOWN, 200, 200, 48'd1000000));
      directed_rows.push_back(plain(FUNC_MOVE, 224, 176, 48'd1000001));
      directed_rows.push_back(expect_nothing(plain(FUNC_TICK, 0, 0, 48'd1599999)));
      directed_rows.push_back(expect_gesture(plain(FUNC_TICK, 0, 0, 48'd1600000),
                                             GESTURE_LONG_PRESS, 200, 200));
      directed_rows.push_back(expect_nothing(plain(FUNC_TICK, 0, 0, 48'd1700000)));
      directed_rows.push_back(expect_nothing(plain(FUNC_UP, 200, 200, 48'd1700001)));
      directed_rows.push_back(plain(FUNC_DOWN, 300, 300, 48'd2000000));
      directed_rows.push_back(plain(FUNC_MOVE, 325, 300, 48'd2000001));
      directed_rows.push_back(expect_nothing(plain(FUNC_UP, 300, 300, 48'd2000002)));
      directed_rows.push_back(plain(FUNC_DOWN, 1, 1, 48'd3000000));
      directed_rows.push_back(plain(FUNC_CANCEL, 0, 0, 48'd3000001));
      directed_rows.push_back(expect_nothing(plain(FUNC_UP, 1, 1, 48'd3000002)));
      // A second down restarts the press; the time wraps past the top.
      directed_rows.push_back(plain(FUNC_DOWN, 7, 7, 48'hFFFF_FFFF_FFFF));
      directed_rows.push_back(plain(FUNC_DOWN, 50, 60, 48'hFFFF_FFFF_FFFF));
      directed_rows.push_back(expect_gesture(plain(FUNC_UP, 50, 60, 48'd3),
                                             GESTURE_TAP, 50, 60));
      // Time running backwards still counts as a short press.
      directed_rows.push_back(plain(FUNC_DOWN, 10, 10, 48'd5000000));
      directed_rows.push_back(expect_gesture(plain(FUNC_UP, 12, 11, 48'd4000000),
                                             GESTURE_TAP, 10, 10));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_request(directed_rows[i]);

      clock_us = any_time();
      random_phase(40);
      holdoff_pending = 1'b1;
      random_phase(80);
      pause_until_drained();

      load_settings(12'd4095, 12'd4095, 8'd255, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      random_phase(100);
      pause_until_drained();

      load_settings(12'd0, 12'd0, 8'd0, 8'd0, 32'd0, 32'd0);
      random_phase(100);
      pause_until_drained();

      load_settings(12'($urandom_range(0, 80)), 12'($urandom_range(20, 400)),
                    8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
                    $urandom_range(0, 2000000), $urandom_range(0, 3000000));
      random_phase(100);
      pause_until_drained();

      load_settings(12'd10, 12'd100, 8'd0, 8'd255, 32'd100000, 32'd200000);
      random_phase(100);
      pause_until_drained();

      load_settings(12'd40, 12'd30, 8'd255, 8'd0, 32'd1000000, 32'd50000);
      random_phase(100);
      pause_until_drained();

      if (error_count == 0 && pending_gestures.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
